>>> hdl/cfr_pkg.sv
// Package for the command frame receiver.
// Holds the payload types, the frame byte codes, the reply codes and the CRC-8 update.
// It depends on nothing else.
package cfr_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [1:0] reply_type;

   localparam byte_type HDR_BYTE  = 8'hFF;
   localparam byte_type ACK_BYTE  = 8'hAA;
   localparam byte_type TAIL_BYTE = 8'h55;

   localparam byte_type ID_LAMP   = 8'h20;
   localparam byte_type ID_SERVO  = 8'h40;
   localparam byte_type ID_BUZZER = 8'h80;

   localparam byte_type CRC_POLY  = 8'h07;
   localparam byte_type CRC_INIT  = 8'hFF;
   localparam byte_type CRC_MSB   = 8'h80;

   localparam reply_type REPLY_NONE    = 2'd0;
   localparam reply_type REPLY_OK      = 2'd1;
   localparam reply_type REPLY_CRC_ERR = 2'd2;

   // CRC-8, MSB first, one whole byte per call.
   function automatic byte_type crc_feed(input byte_type crc, input byte_type data);
      byte_type c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_MSB) != 8'h00) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

>>> hdl/cfr_req_if.sv
// Request channel of the command frame receiver: one received byte per request.
// Depends on cfr_pkg.
interface cfr_req_if;
   logic              valid;
   logic              ready;
   cfr_pkg::byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> hdl/cfr_rsp_if.sv
// Result channel of the command frame receiver: mode registers and the reply code.
// Depends on cfr_pkg.
interface cfr_rsp_if;
   logic               valid;
   logic               ready;
   cfr_pkg::byte_type  lamp_mode;
   cfr_pkg::byte_type  arm_mode;
   cfr_pkg::byte_type  tone_mode;
   cfr_pkg::reply_type reply_code;

   modport source (output valid, output lamp_mode, output arm_mode,
                   output tone_mode, output reply_code, input ready);
   modport sink   (input valid, input lamp_mode, input arm_mode,
                   input tone_mode, input reply_code, output ready);
endinterface

>>> hdl/command_frame_receiver.sv
// Command frame receiver: each accepted request passes the input and result registers.
// Throughput is one request per cycle; the input register, the frame state update and
// the result register form a two-stage pipeline that stalls only on result back pressure.
// Synchronous active-high reset returns to header hunt with the CRC at 0xFF and all
// mode registers at zero. Depends on cfr_pkg, cfr_req_if and cfr_rsp_if.
module command_frame_receiver (
   input logic     clock,
   input logic     reset,
   cfr_req_if.sink req_if,
   cfr_rsp_if.source rsp_if
);

   localparam logic [2:0] PH_HUNT  = 3'd0;
   localparam logic [2:0] PH_COUNT = 3'd1;
   localparam logic [2:0] PH_ID    = 3'd2;
   localparam logic [2:0] PH_VALUE = 3'd3;
   localparam logic [2:0] PH_ACK   = 3'd4;
   localparam logic [2:0] PH_CRC   = 3'd5;
   localparam logic [2:0] PH_TAIL  = 3'd6;

   logic               s1_valid_ff;
   cfr_pkg::byte_type  s1_byte_ff;
   logic               rsp_valid_ff;
   logic               advance;

   logic [2:0]         phase_ff, phase_in;
   cfr_pkg::byte_type  pairs_ff, pairs_in;
   cfr_pkg::byte_type  id_ff, id_in;
   cfr_pkg::byte_type  crc_ff, crc_in;
   cfr_pkg::byte_type  lamp_ff, lamp_in;
   cfr_pkg::byte_type  servo_ff, servo_in;
   cfr_pkg::byte_type  buzzer_ff, buzzer_in;
   cfr_pkg::reply_type reply_ff, reply_in;
   cfr_pkg::byte_type  crc_fed;
   cfr_pkg::byte_type  pairs_dec;

   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !s1_valid_ff || advance;

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.lamp_mode  = lamp_ff;
   assign rsp_if.arm_mode   = servo_ff;
   assign rsp_if.tone_mode  = buzzer_ff;
   assign rsp_if.reply_code = reply_ff;

   assign crc_fed   = cfr_pkg::crc_feed(crc_ff, s1_byte_ff);
   assign pairs_dec = pairs_ff - 8'd1;

   always_comb begin
      phase_in  = phase_ff;
      pairs_in  = pairs_ff;
      id_in     = id_ff;
      crc_in    = crc_ff;
      lamp_in   = lamp_ff;
      servo_in  = servo_ff;
      buzzer_in = buzzer_ff;
      reply_in  = cfr_pkg::REPLY_NONE;
      unique case (phase_ff)
         PH_HUNT: begin
            if (s1_byte_ff == cfr_pkg::HDR_BYTE) begin
               crc_in   = crc_fed;
               phase_in = PH_COUNT;
            end
         end
         PH_COUNT: begin
            crc_in   = crc_fed;
            pairs_in = s1_byte_ff;
            phase_in = PH_ID;
         end
         PH_ID: begin
            crc_in   = crc_fed;
            id_in    = s1_byte_ff;
            phase_in = PH_VALUE;
         end
         PH_VALUE: begin
            crc_in   = crc_fed;
            priority if (id_ff == cfr_pkg::ID_LAMP) begin
               lamp_in = s1_byte_ff;
            end else if (id_ff == cfr_pkg::ID_SERVO) begin
               servo_in = s1_byte_ff;
            end else if (id_ff == cfr_pkg::ID_BUZZER) begin
               buzzer_in = s1_byte_ff;
            end else begin
               lamp_in = lamp_ff;
            end
            pairs_in = pairs_dec;
            phase_in = (pairs_dec == 8'd0) ? PH_ACK : PH_ID;
         end
         PH_ACK: begin
            if (s1_byte_ff == cfr_pkg::ACK_BYTE) begin
               crc_in   = crc_fed;
               phase_in = PH_CRC;
            end
         end
         PH_CRC: begin
            if (s1_byte_ff == crc_ff) begin
               phase_in = PH_TAIL;
            end else begin
               phase_in = PH_HUNT;
               crc_in   = cfr_pkg::CRC_INIT;
               id_in    = 8'h00;
               reply_in = cfr_pkg::REPLY_CRC_ERR;
            end
         end
         default: begin
            if (s1_byte_ff == cfr_pkg::TAIL_BYTE) begin
               phase_in = PH_HUNT;
               crc_in   = cfr_pkg::CRC_INIT;
               id_in    = 8'h00;
               reply_in = cfr_pkg::REPLY_OK;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_HUNT;
         pairs_ff     <= 8'h00;
         id_ff        <= 8'h00;
         crc_ff       <= cfr_pkg::CRC_INIT;
         lamp_ff      <= 8'h00;
         servo_ff     <= 8'h00;
         buzzer_ff    <= 8'h00;
      end else begin
         if (req_if.ready) begin
            s1_valid_ff <= req_if.valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            phase_ff     <= phase_in;
            pairs_ff     <= pairs_in;
            id_ff        <= id_in;
            crc_ff       <= crc_in;
            lamp_ff      <= lamp_in;
            servo_ff     <= servo_in;
            buzzer_ff    <= buzzer_in;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready) begin
         s1_byte_ff <= req_if.rx_byte;
      end
      if (advance) begin
         reply_ff <= reply_in;
      end
   end

`ifndef ASSERT_OFF
   // A frame that has just ended leaves the receiver hunting with a fresh CRC.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && reply_ff != cfr_pkg::REPLY_NONE) |->
         (phase_ff == PH_HUNT && crc_ff == cfr_pkg::CRC_INIT && id_ff == 8'h00))
      else $error("frame end did not restart the receiver");

   // Only the header byte has entered the CRC when the count byte is awaited.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_COUNT) |->
         (crc_ff == cfr_pkg::crc_feed(cfr_pkg::CRC_INIT, cfr_pkg::HDR_BYTE)))
      else $error("CRC after header is wrong");

   // The frame state moves only when a result is produced.
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(phase_ff) && $stable(crc_ff) && $stable(pairs_ff)))
      else $error("frame state changed without a result");
`endif

endmodule

>>> bench/testbench.sv
// Testbench for command_frame_receiver: drives frames, noise and broken byte runs with random
// bursts and stalls, predicts every result and compares it field by field.
// Depends on cfr_pkg, cfr_req_if, cfr_rsp_if and command_frame_receiver.
`timescale 1ns / 1ps

module testbench;

   localparam int ITEM_TARGET = 1450;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;
   localparam int REPORT_LIMIT = 10;

   typedef enum logic [2:0] {
      ST_HUNT, ST_COUNT, ST_ID, ST_VALUE, ST_ACK, ST_CRC, ST_TAIL
   } frame_phase_type;

   typedef struct packed {
      cfr_pkg::byte_type  lamp;
      cfr_pkg::byte_type  servo;
      cfr_pkg::byte_type  buzzer;
      cfr_pkg::reply_type reply;
   } frame_status_type;

   class frame_scoreboard;
      frame_status_type  expected_status[$];
      frame_phase_type   phase;
      cfr_pkg::byte_type pairs_left;
      cfr_pkg::byte_type current_id;
      cfr_pkg::byte_type crc;
      cfr_pkg::byte_type lamp;
      cfr_pkg::byte_type servo;
      cfr_pkg::byte_type buzzer;
      int                mismatches;

      function new();
         phase = ST_HUNT;
         pairs_left = 8'h00;
         current_id = 8'h00;
         crc = cfr_pkg::CRC_INIT;
         lamp = 8'h00;
         servo = 8'h00;
         buzzer = 8'h00;
         mismatches = 0;
      endfunction

      static function cfr_pkg::byte_type crc8_step(input cfr_pkg::byte_type state,
                                                   input cfr_pkg::byte_type data);
         cfr_pkg::byte_type r;
         logic              fb;
         r = state;
         for (int i = 7; i >= 0; i--) begin
            fb = r[7] ^ data[i];
            r = {r[6:0], 1'b0} ^ (fb ? cfr_pkg::CRC_POLY : 8'h00);
         end
         return r;
      endfunction

      function void restart_frame();
         phase = ST_HUNT;
         crc = cfr_pkg::CRC_INIT;
         current_id = 8'h00;
      endfunction

      function void note_request(input cfr_pkg::byte_type b);
         frame_status_type s;
         s.reply = cfr_pkg::REPLY_NONE;
         case (phase)
            ST_HUNT: begin
               if (b == cfr_pkg::HDR_BYTE) begin
                  crc = crc8_step(crc, b);
                  phase = ST_COUNT;
               end
            end
            ST_COUNT: begin
               crc = crc8_step(crc, b);
               pairs_left = b;
               phase = ST_ID;
            end
            ST_ID: begin
               crc = crc8_step(crc, b);
               current_id = b;
               phase = ST_VALUE;
            end
            ST_VALUE: begin
               crc = crc8_step(crc, b);
               if (current_id == cfr_pkg::ID_LAMP) begin
                  lamp = b;
               end else if (current_id == cfr_pkg::ID_SERVO) begin
                  servo = b;
               end else if (current_id == cfr_pkg::ID_BUZZER) begin
                  buzzer = b;
               end
               pairs_left = pairs_left - 8'd1;
               if (pairs_left == 8'h00) begin
                  phase = ST_ACK;
               end else begin
                  phase = ST_ID;
               end
            end
            ST_ACK: begin
               if (b == cfr_pkg::ACK_BYTE) begin
                  crc = crc8_step(crc, b);
                  phase = ST_CRC;
               end
            end
            ST_CRC: begin
               if (b == crc) begin
                  phase = ST_TAIL;
               end else begin
                  restart_frame();
                  s.reply = cfr_pkg::REPLY_CRC_ERR;
               end
            end
            default: begin
               if (b == cfr_pkg::TAIL_BYTE) begin
                  restart_frame();
                  s.reply = cfr_pkg::REPLY_OK;
               end
            end
         endcase
         s.lamp = lamp;
         s.servo = servo;
         s.buzzer = buzzer;
         expected_status.push_back(s);
      endfunction

      function void check_status(input frame_status_type got);
         frame_status_type want;
         if (expected_status.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("Unexpected result: lamp %h servo %h buzzer %h reply %0d",
                        got.lamp, got.servo, got.buzzer, got.reply);
            end
            return;
         end
         want = expected_status.pop_front();
         if (got.lamp !== want.lamp || got.servo !== want.servo ||
             got.buzzer !== want.buzzer || got.reply !== want.reply) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("Mismatch: lamp %h/%h servo %h/%h buzzer %h/%h reply %0d/%0d",
                        want.lamp, got.lamp, want.servo, got.servo,
                        want.buzzer, got.buzzer, want.reply, got.reply);
            end
         end
      endfunction

      function int pending();
         return expected_status.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   int   cycle_count = 0;
   int   burst_left = 0;
   int   frame_bytes_sent = 0;
   bit   hold_off_req = 1'b0;

   cfr_pkg::byte_type pair_ids[$];
   cfr_pkg::byte_type pair_values[$];

   frame_scoreboard sb;

   cfr_req_if req_ch ();
   cfr_rsp_if rsp_ch ();

   command_frame_receiver u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send_byte(input cfr_pkg::byte_type b, input bit counted);
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(50, 200);
         end else begin
            burst_left = $urandom_range(1, 20);
         end
      end
      req_ch.valid <= 1'b1;
      req_ch.rx_byte <= b;
      do begin
         @(posedge clock);
      end while (req_ch.ready !== 1'b1);
      sb.note_request(b);
      burst_left--;
      if (counted) begin
         frame_bytes_sent++;
      end
   endtask

   task automatic send_noise(input int n, input cfr_pkg::byte_type awaited);
      cfr_pkg::byte_type b;
      repeat (n) begin
         b = cfr_pkg::byte_type'($urandom);
         while (b == awaited) begin
            b = cfr_pkg::byte_type'($urandom);
         end
         send_byte(b, 1'b0);
      end
   endtask

   // The pair count byte is the low eight bits of the pair total, so 256 pairs send zero.
   task automatic send_frame(input bit corrupt, input bit noisy);
      cfr_pkg::byte_type crc;
      cfr_pkg::byte_type count;
      count = cfr_pkg::byte_type'(pair_ids.size());
      crc = cfr_pkg::CRC_INIT;
      if (noisy) begin
         send_noise($urandom_range(1, 3), cfr_pkg::HDR_BYTE);
      end
      send_byte(cfr_pkg::HDR_BYTE, 1'b1);
      crc = frame_scoreboard::crc8_step(crc, cfr_pkg::HDR_BYTE);
      send_byte(count, 1'b1);
      crc = frame_scoreboard::crc8_step(crc, count);
      foreach (pair_ids[i]) begin
         send_byte(pair_ids[i], 1'b1);
         crc = frame_scoreboard::crc8_step(crc, pair_ids[i]);
         send_byte(pair_values[i], 1'b1);
         crc = frame_scoreboard::crc8_step(crc, pair_values[i]);
      end
      if (noisy) begin
         send_noise($urandom_range(1, 3), cfr_pkg::ACK_BYTE);
      end
      send_byte(cfr_pkg::ACK_BYTE, 1'b1);
      crc = frame_scoreboard::crc8_step(crc, cfr_pkg::ACK_BYTE);
      if (corrupt) begin
         send_byte(crc ^ cfr_pkg::byte_type'($urandom_range(1, 255)), 1'b1);
      end else begin
         send_byte(crc, 1'b1);
         if (noisy) begin
            send_noise($urandom_range(1, 3), cfr_pkg::TAIL_BYTE);
         end
         send_byte(cfr_pkg::TAIL_BYTE, 1'b1);
      end
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic pick_pairs(input int pairs);
      pair_ids.delete();
      pair_values.delete();
      repeat (pairs) begin
         case ($urandom_range(0, 4))
            0: pair_ids.push_back(cfr_pkg::ID_LAMP);
            1: pair_ids.push_back(cfr_pkg::ID_SERVO);
            2: pair_ids.push_back(cfr_pkg::ID_BUZZER);
            default: pair_ids.push_back(cfr_pkg::byte_type'($urandom));
         endcase
         pair_values.push_back(cfr_pkg::byte_type'($urandom));
      end
   endtask

   // The result sink runs fully open, half open, mostly closed and held-off stretches.
   initial begin
      frame_status_type got;
      int hold;
      int mode;
      int mode_cycles;
      hold = 0;
      mode = 0;
      mode_cycles = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got.lamp = rsp_ch.lamp_mode;
            got.servo = rsp_ch.arm_mode;
            got.buzzer = rsp_ch.tone_mode;
            got.reply = rsp_ch.reply_code;
            sb.check_status(got);
         end
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold = HOLD_CYCLES;
         end
         if (hold > 0) begin
            hold--;
            rsp_ch.ready <= 1'b0;
         end else begin
            if (mode_cycles == 0) begin
               mode = $urandom_range(0, 2);
               mode_cycles = $urandom_range(10, 80);
            end
            mode_cycles--;
            case (mode)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= 1'($urandom_range(0, 1));
               default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   initial begin
      int frame_index;
      int choice;
      int pairs;
      sb = new();
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.rx_byte <= 8'h00;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_byte(8'h00, 1'b1);
      send_byte(cfr_pkg::ACK_BYTE, 1'b1);
      send_byte(cfr_pkg::TAIL_BYTE, 1'b1);
      pair_ids = '{cfr_pkg::ID_LAMP, 8'hFF, 8'h00};
      pair_values = '{8'hFF, 8'h00, 8'h55};
      send_frame(1'b0, 1'b1);
      pair_ids = '{cfr_pkg::ID_SERVO};
      pair_values = '{8'h7F};
      send_frame(1'b1, 1'b0);
      pair_ids = '{cfr_pkg::ID_BUZZER, cfr_pkg::ID_LAMP, cfr_pkg::ID_SERVO};
      pair_values = '{8'h80, 8'h00, 8'h01};
      send_frame(1'b0, 1'b0);
      drain_results();

      frame_index = 0;
      while (frame_bytes_sent < ITEM_TARGET) begin
         choice = $urandom_range(0, 99);
         if (frame_index == 2) begin
            pick_pairs(256);
            send_frame(1'b0, 1'b0);
         end else if (choice < 8) begin
            repeat ($urandom_range(1, 12)) begin
               send_byte(cfr_pkg::byte_type'($urandom), 1'b1);
            end
         end else begin
            if (choice < 10 && frame_bytes_sent + 600 < ITEM_TARGET) begin
               pairs = $urandom_range(100, 255);
            end else begin
               pairs = $urandom_range(1, 8);
            end
            pick_pairs(pairs);
            send_frame($urandom_range(0, 6) == 0, $urandom_range(0, 3) == 0);
         end
         frame_index++;
         if (frame_index == 20) begin
            hold_off_req = 1'b1;
         end
         if (frame_index == 45) begin
            drain_results();
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
